/* rtl/gsi_pkg.sv */
// gsi_pkg: shared types and codes of the gain schedule interpolator
// transaction structs, table entry layout, status and mode codes
// no dependencies
package gsi_pkg;

    typedef logic signed [15:0] q412_t;

    typedef struct packed {
        logic               mode;
        logic [3:0]         entry_index;
        logic signed [15:0] breakpoint_value;
        q412_t              kp_value;
        q412_t              ki_value;
        q412_t              kd_value;
        logic signed [15:0] operating_value;
    } cmd_t;

    typedef struct packed {
        logic [1:0] status;
        q412_t      kp_out;
        q412_t      ki_out;
        q412_t      kd_out;
    } rsp_t;

    typedef struct packed {
        logic signed [15:0] bp;
        q412_t              kp;
        q412_t              ki;
        q412_t              kd;
    } entry_t;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_EMPTY  = 2'd1;
    localparam logic [1:0] STATUS_REJECT = 2'd2;

    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_WRITE  = 1'b1;

    localparam logic [1:0] GAIN_P = 2'd0;
    localparam logic [1:0] GAIN_I = 2'd1;
    localparam logic [1:0] GAIN_D = 2'd2;

    function automatic q412_t entry_gain(entry_t e, logic [1:0] sel);
        q412_t g;
        case (sel)
            GAIN_P:  g = e.kp;
            GAIN_I:  g = e.ki;
            GAIN_D:  g = e.kd;
            default: g = e.kp;
        endcase
        return g;
    endfunction

endpackage

/* rtl/gsi_table.sv */
// gsi_table: breakpoint table memory, one write port, one read port
// synchronous read, rd_data registered in the cycle after rd_en; uses gsi_pkg
module gsi_table
    import gsi_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  entry_t            wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output entry_t            rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/gsi_divider.sv */
// gsi_divider: restoring divider, one quotient bit per cycle
// forms (num << FACTOR_BITS) / den for num <= den; uses gsi_pkg
module gsi_divider
    import gsi_pkg::*;
#(
    parameter int FACTOR_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [15:0]          num,
    input  logic [15:0]          den,
    output logic                 done,
    output logic [FACTOR_BITS:0] quo
);

    localparam int CNT_W = $clog2(FACTOR_BITS + 1);

    logic [16:0]            rem_reg, rem_next;
    logic [15:0]            den_reg, den_next;
    logic [FACTOR_BITS:0]   quo_reg, quo_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   active_reg, active_next;
    logic                   done_reg, done_next;
    logic [16:0]            rem_dbl;
    logic                   fits;

    assign rem_dbl = {rem_reg[15:0], 1'b0};
    assign fits    = rem_dbl >= {1'b0, den_reg};

    always_comb
    begin
        rem_next    = rem_reg;
        den_next    = den_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        active_next = active_reg;
        done_next   = 1'b0;
        if (start)
        begin
            // num equals den only at the top of a segment
            rem_next    = (num == den) ? 17'd0 : {1'b0, num};
            den_next    = den;
            quo_next    = (FACTOR_BITS + 1)'(num == den);
            cnt_next    = CNT_W'(FACTOR_BITS);
            active_next = 1'b1;
        end
        else if (active_reg)
        begin
            rem_next = fits ? (rem_dbl - {1'b0, den_reg}) : rem_dbl;
            quo_next = {quo_reg[FACTOR_BITS-1:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

/* rtl/gsi_lerp.sv */
// gsi_lerp: interpolates the three gains one after another on one multiplier
// lo + floor(factor * (hi - lo) / 2^FACTOR_BITS), saturated; uses gsi_pkg
module gsi_lerp
    import gsi_pkg::*;
#(
    parameter int FACTOR_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [FACTOR_BITS:0] factor,
    input  entry_t               lo,
    input  entry_t               hi,
    output logic                 done,
    output q412_t                kp,
    output q412_t                ki,
    output q412_t                kd
);

    localparam int PROD_W = FACTOR_BITS + 19;

    logic [2:0]                step_reg, step_next;
    logic                      active_reg, active_next;
    logic                      done_reg, done_next;
    logic signed [PROD_W-1:0]  prod_reg;
    q412_t                     res_reg [3];
    logic [1:0]                sel;
    q412_t                     lo_gain;
    q412_t                     hi_gain;
    logic signed [16:0]        diff;
    logic signed [FACTOR_BITS+1:0] fac_s;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [PROD_W-1:0]  prod_shr;
    logic signed [19:0]        sum;
    q412_t                     sat;

    assign sel       = step_reg[2:1];
    assign lo_gain   = entry_gain(lo, sel);
    assign hi_gain   = entry_gain(hi, sel);
    assign diff      = {hi_gain[15], hi_gain} - {lo_gain[15], lo_gain};
    assign fac_s     = $signed({1'b0, factor});
    assign prod_next = fac_s * diff;
    assign prod_shr  = prod_reg >>> FACTOR_BITS;
    assign sum       = 20'(lo_gain) + 20'(prod_shr);

    always_comb
    begin
        if (sum > 20'sd32767)
        begin
            sat = 16'sh7fff;
        end
        else if (sum < -20'sd32768)
        begin
            sat = 16'sh8000;
        end
        else
        begin
            sat = sum[15:0];
        end
    end

    always_comb
    begin
        step_next   = step_reg;
        active_next = active_reg;
        done_next   = 1'b0;
        if (start)
        begin
            step_next   = 3'd0;
            active_next = 1'b1;
        end
        else if (active_reg)
        begin
            step_next = step_reg + 3'd1;
            if (step_reg == 3'd5)
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= 3'd0;
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            step_reg   <= step_next;
            active_reg <= active_next;
            done_reg   <= done_next;
        end
    end

    // even steps multiply, odd steps add and saturate
    always_ff @(posedge clk)
    begin
        if (active_reg && !step_reg[0])
        begin
            prod_reg <= prod_next;
        end
        if (active_reg && step_reg[0])
        begin
            res_reg[sel] <= sat;
        end
    end

    assign done = done_reg;
    assign kp   = res_reg[GAIN_P];
    assign ki   = res_reg[GAIN_I];
    assign kd   = res_reg[GAIN_D];

endmodule

/* rtl/gain_schedule_interpolator_core.sv */
// gain_schedule_interpolator_core: top level of the gain schedule interpolator
// controller and table state; uses gsi_pkg, gsi_table, gsi_divider, gsi_lerp
//
// usage: a transaction is taken on cmd at a clock edge with start high and
// busy low. mode write stores one breakpoint entry, mode lookup returns the
// P, I and D gains interpolated at operating_value. every transaction gives
// one result on rsp, marked by done for exactly one cycle; the receiver
// cannot stall, so the result must be taken in that cycle.
// a rejected write or an index 0 write is answered straight from idle; a
// checked write makes one table read of the previous entry first. a lookup
// on an empty table is answered from idle; otherwise entries are read one per
// cycle, up to POINTS, then, inside a segment, the serial divider forms the
// factor, then the shared multiplier makes its three multiply and add passes.
// busy is high after acceptance until the result shows, but not for a result
// given from idle; the next transaction can be taken in the cycle it shows.
// reset clears the entry count, so the table reads as empty; the table
// memory itself is not cleared and needs no clearing pass.
module gain_schedule_interpolator_core
    import gsi_pkg::*;
#(
    parameter int POINTS      = 16,
    parameter int FACTOR_BITS = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  cmd_t cmd,
    output logic busy,
    output logic done,
    output rsp_t rsp
);

    localparam int IDX_W = $clog2(POINTS);
    localparam int CNT_W = $clog2(POINTS + 1);
    localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WCHK = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_LERP = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     scan_reg, scan_next;
    cmd_t                 cmd_reg, cmd_next;
    entry_t               prev_reg, prev_next;
    entry_t               lo_reg, lo_next;
    entry_t               hi_reg, hi_next;
    logic [FACTOR_BITS:0] factor_reg, factor_next;
    logic                 done_reg, done_next;
    rsp_t                 rsp_reg, rsp_next;

    cmd_t                 cur_cmd;
    logic [CMP_W-1:0]     idx_ext;
    logic [CMP_W-1:0]     idx_prev;
    logic [CMP_W-1:0]     idx_inc;
    entry_t               new_entry;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    entry_t               rd_data;
    logic                 scan_last;
    logic signed [16:0]   num_full;
    logic signed [16:0]   den_full;
    logic                 div_start;
    logic                 div_done;
    logic [FACTOR_BITS:0] div_quo;
    logic                 lerp_start;
    logic                 lerp_done;
    q412_t                lerp_kp, lerp_ki, lerp_kd;

    assign cur_cmd   = (state_reg == S_IDLE) ? cmd : cmd_reg;
    assign idx_ext   = CMP_W'(cur_cmd.entry_index);
    assign idx_prev  = idx_ext - CMP_W'(1);
    assign idx_inc   = idx_ext + CMP_W'(1);
    assign wr_addr   = idx_ext[IDX_W-1:0];
    assign scan_last = CNT_W'(scan_reg) == (count_reg - CNT_W'(1));
    assign num_full  = {cmd_reg.operating_value[15], cmd_reg.operating_value}
                     - {prev_reg.bp[15], prev_reg.bp};
    assign den_full  = {rd_data.bp[15], rd_data.bp} - {prev_reg.bp[15], prev_reg.bp};

    always_comb
    begin
        new_entry.bp = cur_cmd.breakpoint_value;
        new_entry.kp = cur_cmd.kp_value;
        new_entry.ki = cur_cmd.ki_value;
        new_entry.kd = cur_cmd.kd_value;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        scan_next   = scan_reg;
        cmd_next    = cmd_reg;
        prev_next   = prev_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        factor_next = factor_reg;
        done_next   = 1'b0;
        rsp_next    = rsp_reg;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = '0;
        div_start   = 1'b0;
        lerp_start  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    if (cmd.mode == MODE_WRITE)
                    begin
                        if (idx_ext >= CMP_W'(POINTS) || idx_ext > CMP_W'(count_reg))
                        begin
                            done_next       = 1'b1;
                            rsp_next        = '0;
                            rsp_next.status = STATUS_REJECT;
                        end
                        else if (idx_ext == '0)
                        begin
                            wr_en           = 1'b1;
                            count_next      = CNT_W'(1);
                            done_next       = 1'b1;
                            rsp_next        = '0;
                            rsp_next.status = STATUS_OK;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = idx_prev[IDX_W-1:0];
                            state_next = S_WCHK;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        done_next       = 1'b1;
                        rsp_next        = '0;
                        rsp_next.status = STATUS_EMPTY;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        scan_next  = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_WCHK:
            begin
                done_next = 1'b1;
                rsp_next  = '0;
                if (cmd_reg.breakpoint_value > rd_data.bp)
                begin
                    wr_en           = 1'b1;
                    count_next      = CNT_W'(idx_inc);
                    rsp_next.status = STATUS_OK;
                end
                else
                begin
                    rsp_next.status = STATUS_REJECT;
                end
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                if (scan_reg == '0 && (count_reg == CNT_W'(1)
                    || cmd_reg.operating_value <= rd_data.bp))
                begin
                    // below the first breakpoint or a single entry
                    lo_next     = rd_data;
                    hi_next     = rd_data;
                    factor_next = '0;
                    lerp_start  = 1'b1;
                    state_next  = S_LERP;
                end
                else if (scan_reg != '0 && cmd_reg.operating_value <= rd_data.bp)
                begin
                    lo_next    = prev_reg;
                    hi_next    = rd_data;
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else if (scan_last)
                begin
                    // above the last breakpoint
                    lo_next     = rd_data;
                    hi_next     = rd_data;
                    factor_next = '0;
                    lerp_start  = 1'b1;
                    state_next  = S_LERP;
                end
                else
                begin
                    prev_next = rd_data;
                    scan_next = scan_reg + IDX_W'(1);
                    rd_en     = 1'b1;
                    rd_addr   = scan_reg + IDX_W'(1);
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    factor_next = div_quo;
                    lerp_start  = 1'b1;
                    state_next  = S_LERP;
                end
            end
            S_LERP:
            begin
                if (lerp_done)
                begin
                    done_next       = 1'b1;
                    rsp_next.status = STATUS_OK;
                    rsp_next.kp_out = lerp_kp;
                    rsp_next.ki_out = lerp_ki;
                    rsp_next.kd_out = lerp_kd;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg   <= scan_next;
        cmd_reg    <= cmd_next;
        prev_reg   <= prev_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        factor_reg <= factor_next;
        rsp_reg    <= rsp_next;
    end

    gsi_table #(
        .DEPTH  (POINTS),
        .ADDR_W (IDX_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (new_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    gsi_divider #(
        .FACTOR_BITS (FACTOR_BITS)
    ) u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_full[15:0]),
        .den   (den_full[15:0]),
        .done  (div_done),
        .quo   (div_quo)
    );

    gsi_lerp #(
        .FACTOR_BITS (FACTOR_BITS)
    ) u_lerp (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (lerp_start),
        .factor (factor_reg),
        .lo     (lo_reg),
        .hi     (hi_reg),
        .done   (lerp_done),
        .kp     (lerp_kp),
        .ki     (lerp_ki),
        .kd     (lerp_kd)
    );

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_done_follows_transaction: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> ($past(start) || $past(busy)))
        else $error("result without a transaction");

    a_count_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(POINTS))
        else $error("entry count beyond table depth");

    a_no_ok_gains_on_error: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && rsp.status != STATUS_OK)
        |-> (rsp.kp_out == '0 && rsp.ki_out == '0 && rsp.kd_out == '0))
        else $error("nonzero gains on an error result");

    a_status_code: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> (rsp.status == STATUS_OK || rsp.status == STATUS_EMPTY
                  || rsp.status == STATUS_REJECT))
        else $error("undefined status code");

    a_segment_needs_two: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (count_reg >= CNT_W'(2)))
        else $error("segment division with fewer than two entries");

endmodule
